// ===== rtl/mmwg_pkg.sv =====
// package for the multi-mode waveform generator: widths, codes, record types
// and the sine table builder used by the table ROM
// no dependencies
package mmwg_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 512;
	localparam int SINE_IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [SINE_IDX_W-1:0] SINE_IDX_LAST = SINE_IDX_W'(TABLE_DEPTH - 1);

	// configuration register indexes
	localparam logic [1:0] CFG_PERIOD_START = 2'd0;
	localparam logic [1:0] CFG_PERIOD_STEP = 2'd1;
	localparam logic [1:0] CFG_PERIOD_FLOOR = 2'd2;
	localparam logic [1:0] CFG_COMMAND_BYTE = 2'd3;

	// configuration reset values
	localparam logic [15:0] PERIOD_START_RST = 16'd26300;
	localparam logic [15:0] PERIOD_STEP_RST = 16'd1000;
	localparam logic [15:0] PERIOD_FLOOR_RST = 16'd300;
	localparam logic [7:0] COMMAND_BYTE_RST = 8'd17;

	// level at reset, matches the start-up frame
	localparam logic [7:0] LEVEL_RST = 8'd2;
	localparam logic [7:0] LEVEL_MAX = 8'd255;
	localparam logic [7:0] LEVEL_MIN = 8'd0;

	// item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SWITCH = 1'b1;

	// switch pin patterns that do something beyond the reload copy
	localparam logic [1:0] PINS_SPEED = 2'd1;
	localparam logic [1:0] PINS_MODE = 2'd2;

	typedef enum logic [1:0] {
		MODE_TRI = 2'd0,
		MODE_SAW = 2'd1,
		MODE_SQUARE = 2'd2,
		MODE_SINE = 2'd3
	} wave_mode_t;

	// one result word
	typedef struct packed {
		logic frame_valid;
		logic [15:0] frame_word;
		logic [15:0] reload_period;
		logic [1:0] mode_now;
	} result_t;

	// sine table, built at elaboration in Q60 fixed point
	typedef logic [7:0] sine_tab_t [TABLE_DEPTH];

	localparam logic [63:0] SIN_NUM = 64'd6283184;
	localparam logic [63:0] SIN_DEN = 64'd1000000 * 64'(TABLE_DEPTH);
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
	localparam logic [63:0] AMP_Q56 = 64'd127 << 56;

	// (a*b) >> 60 kept to 64 bits
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	function automatic logic [7:0] sine_sample(input int unsigned k);
		logic [63:0] n, q0, r, f1, f2, th, x2, term, sum, y, t, v;
		logic neg;
		n = SIN_NUM * 64'(k);
		q0 = n / SIN_DEN;
		r = n % SIN_DEN;
		f1 = (r << 30) / SIN_DEN;
		r = (r << 30) % SIN_DEN;
		f2 = (r << 30) / SIN_DEN;
		th = (q0 << 60) + (f1 << 30) + f2;
		neg = 1'b0;
		// fold into the first quarter turn
		if (th >= PI_Q60) begin
			th = th - PI_Q60;
			neg = 1'b1;
		end
		if (th > HALF_PI_Q60) begin
			th = PI_Q60 - th;
		end
		x2 = mul_q60(th, th);
		term = th;
		sum = th;
		// taylor series, twelve terms past the first
		for (int j = 1; j <= 12; j++) begin
			term = mul_q60(term, x2);
			case (j)
				1: term = term / 64'd6;
				2: term = term / 64'd20;
				3: term = term / 64'd42;
				4: term = term / 64'd72;
				5: term = term / 64'd110;
				6: term = term / 64'd156;
				7: term = term / 64'd210;
				8: term = term / 64'd272;
				9: term = term / 64'd342;
				10: term = term / 64'd420;
				11: term = term / 64'd506;
				default: term = term / 64'd600;
			endcase
			if (j[0]) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		y = 64'd127 * (sum >> 4);
		if (neg) begin
			t = (y >= AMP_Q56) ? 64'd0 : AMP_Q56 - y;
		end else begin
			t = AMP_Q56 + y;
		end
		v = t >> 56;
		if (v > 64'd255) begin
			v = 64'd255;
		end
		return v[7:0];
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			tab[k] = sine_sample(k);
		end
		return tab;
	endfunction

endpackage

// ===== rtl/mmwg_if.sv =====
// valid/ready channel interfaces for the item and result words
// no dependencies
interface mmwg_item_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [1:0] switch_levels;

	modport source(output valid, output opcode, output switch_levels, input ready);
	modport sink(input valid, input opcode, input switch_levels, output ready);
endinterface

interface mmwg_result_if;
	logic valid;
	logic ready;
	logic frame_valid;
	logic [15:0] frame_word;
	logic [15:0] reload_period;
	logic [1:0] mode_now;

	modport source(output valid, output frame_valid, output frame_word,
		output reload_period, output mode_now, input ready);
	modport sink(input valid, input frame_valid, input frame_word,
		input reload_period, input mode_now, output ready);
endinterface

// ===== rtl/mmwg_sine_rom.sv =====
// synchronous sine table ROM, one read port with registered data
// depends on mmwg_pkg
module mmwg_sine_rom
	import mmwg_pkg::*;
(
	input logic clk,
	input logic rd_en,
	input logic [SINE_IDX_W-1:0] rd_addr,
	output logic [7:0] rd_data
);

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	logic [7:0] data_q;

	// registered read, held while no word is taken in
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= SINE_TAB[rd_addr];
		end
	end

	assign rd_data = data_q;

endmodule

// ===== rtl/mmwg_skid.sv =====
// two-entry output buffer: output register plus skid register
// depends on mmwg_pkg and mmwg_if
module mmwg_skid
	import mmwg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input result_t in_data,
	mmwg_result_if.source result
);

	logic main_valid_q;
	logic skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic main_free;

	assign main_free = !main_valid_q || result.ready;
	assign in_ready = !skid_valid_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_valid && in_ready) begin
			skid_q <= in_data;
		end
	end

	assign result.valid = main_valid_q;
	assign result.frame_valid = main_q.frame_valid;
	assign result.frame_word = main_q.frame_word;
	assign result.reload_period = main_q.reload_period;
	assign result.mode_now = main_q.mode_now;

endmodule

// ===== rtl/multi_mode_waveform_generator.sv =====
// top level of the multi-mode waveform generator: sequencer state, first stage
// depends on mmwg_pkg, mmwg_if, mmwg_sine_rom, mmwg_skid

// Takes one word per clock while the buffer has room: a tick steps the 8-bit
// level in the current mode (triangle, sawtooth, square, or sine from a
// 512-entry synchronous ROM) and returns the frame command_byte:level; a
// switch word copies the period into the reload value and then, by its pin
// pattern, lowers or restarts the period or cycles the mode. Every word
// gives exactly one result word, carrying the reload value and mode after
// it. Sequencer state updates at the accepting edge, so a new word may
// follow in the very next cycle; the ROM read issued at that edge fills the
// first stage. A two-entry output buffer keeps input accepting while one
// result waits on a stalled output. Configuration writes are taken at any
// edge with cfg_we high and should land only while the block is idle.
module multi_mode_waveform_generator
	import mmwg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_wdata,
	mmwg_item_if.sink item,
	mmwg_result_if.source result
);

	typedef struct packed {
		logic is_tick;
		logic use_rom;
		logic [7:0] level;
		logic [7:0] cmd;
		logic [15:0] reload;
		wave_mode_t mode;
	} s1_t;

	// configuration registers
	logic [15:0] period_start_q;
	logic [15:0] period_step_q;
	logic [15:0] period_floor_q;
	logic [7:0] command_byte_q;

	// sequencer state
	logic [7:0] level_q;
	logic going_down_q;
	wave_mode_t mode_q;
	logic [SINE_IDX_W-1:0] sine_idx_q;
	logic [15:0] period_q;
	logic [15:0] reload_q;

	logic [7:0] level_d;
	logic going_down_d;
	wave_mode_t mode_d;
	logic [SINE_IDX_W-1:0] sine_idx_d;
	logic [15:0] period_d;
	logic [15:0] reload_d;

	logic v_s1;
	s1_t data_s1;
	s1_t next_s1;
	logic [7:0] rom_data;
	logic buf_ready;
	logic acc;
	logic [16:0] wrap_limit;
	result_t buf_data;

	assign item.ready = !v_s1 || buf_ready;
	assign acc = item.valid && item.ready;
	assign wrap_limit = {1'b0, period_floor_q} + {1'b0, period_step_q};

	// configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_start_q <= PERIOD_START_RST;
			period_step_q <= PERIOD_STEP_RST;
			period_floor_q <= PERIOD_FLOOR_RST;
			command_byte_q <= COMMAND_BYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PERIOD_START: period_start_q <= cfg_wdata;
				CFG_PERIOD_STEP: period_step_q <= cfg_wdata;
				CFG_PERIOD_FLOOR: period_floor_q <= cfg_wdata;
				CFG_COMMAND_BYTE: command_byte_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// next sequencer state for the word at the input
	always_comb begin
		level_d = level_q;
		going_down_d = going_down_q;
		mode_d = mode_q;
		sine_idx_d = sine_idx_q;
		period_d = period_q;
		reload_d = reload_q;
		if (item.opcode == OP_TICK) begin
			case (mode_q)
				MODE_TRI: begin
					if (!going_down_q) begin
						level_d = level_q + 8'd1;
						going_down_d = (level_d == LEVEL_MAX);
					end else begin
						level_d = level_q - 8'd1;
						going_down_d = (level_d != LEVEL_MIN);
					end
				end
				MODE_SAW: level_d = level_q + 8'd1;
				MODE_SQUARE: begin
					level_d = going_down_q ? LEVEL_MIN : LEVEL_MAX;
					going_down_d = !going_down_q;
				end
				default: begin
					sine_idx_d = (sine_idx_q == SINE_IDX_LAST) ?
						'0 : sine_idx_q + SINE_IDX_W'(1);
				end
			endcase
		end else begin
			reload_d = period_q;
			if (item.switch_levels == PINS_SPEED) begin
				period_d = ({1'b0, period_q} <= wrap_limit) ?
					period_start_q : period_q - period_step_q;
			end else if (item.switch_levels == PINS_MODE) begin
				mode_d = wave_mode_t'(mode_q + 2'd1);
			end
		end
	end

	// state registers, updated at the accepting edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RST;
			going_down_q <= 1'b0;
			mode_q <= MODE_TRI;
			sine_idx_q <= '0;
			period_q <= PERIOD_START_RST;
			reload_q <= PERIOD_START_RST;
		end else if (acc) begin
			level_q <= level_d;
			going_down_q <= going_down_d;
			mode_q <= mode_d;
			sine_idx_q <= sine_idx_d;
			period_q <= period_d;
			reload_q <= reload_d;
		end
	end

	// sine table read at the current index
	mmwg_sine_rom u_rom (
		.clk(clk),
		.rd_en(acc),
		.rd_addr(sine_idx_q),
		.rd_data(rom_data)
	);

	// first stage record
	always_comb begin
		next_s1.is_tick = (item.opcode == OP_TICK);
		next_s1.use_rom = (mode_q == MODE_SINE);
		next_s1.level = level_d;
		next_s1.cmd = command_byte_q;
		next_s1.reload = reload_d;
		next_s1.mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (buf_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			data_s1 <= next_s1;
		end
	end

	// form the result word
	always_comb begin
		buf_data.frame_valid = data_s1.is_tick;
		buf_data.frame_word = data_s1.is_tick ?
			{data_s1.cmd, (data_s1.use_rom ? rom_data : data_s1.level)} : 16'd0;
		buf_data.reload_period = data_s1.reload;
		buf_data.mode_now = data_s1.mode;
	end

	mmwg_skid u_skid (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s1),
		.in_ready(buf_ready),
		.in_data(buf_data),
		.result(result)
	);

	// mode moves only on an accepted mode-cycle switch word
	a_mode_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(mode_q) |-> $past(acc && item.opcode == OP_SWITCH &&
			item.switch_levels == PINS_MODE))
		else $error("mode changed without a mode switch word");

	// sine index moves only on an accepted tick in sine mode
	a_idx_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sine_idx_q) |-> $past(acc && item.opcode == OP_TICK &&
			mode_q == MODE_SINE))
		else $error("sine index moved outside a sine tick");

	// a switch word copies the period into the reload value
	a_reload_copy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && item.opcode == OP_SWITCH |=> reload_q == $past(period_q))
		else $error("reload value not copied from period");

	// input stalls only while the first stage holds a word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> v_s1 && !buf_ready)
		else $error("input stalled with room in the pipeline");

endmodule
